// ----- rtl/sol2ls_pkg.sv -----
// Shared types and fixed-point constants for the sol to solar longitude block.
// Constants are worked out at elaboration by the functions below.
// Depends on nothing.
package sol2ls_pkg;

  localparam int FRAC_W    = 28;
  localparam int WORD_W    = FRAC_W + 6;
  localparam int MUL_W     = 32;
  localparam int KDIV_W    = 23;
  localparam int DCNT_W    = 5;
  localparam int ATAN_DEPTH = 40;
  localparam int ATAN_IDX_W = 6;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t atan_tab_t [ATAN_DEPTH];

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;
  localparam logic [63:0] PI_DEC  = 64'd3141592653589793238;
  localparam logic [63:0] GAIN_DEC = 64'd607252935008881256;

  localparam logic [WORD_W-1:0] SOL_SCALE  = WORD_W'(66860);
  localparam logic [WORD_W-1:0] HALF_SCALE = WORD_W'(33430);
  localparam logic [22:0]       PERI_SOL100 = 23'd48535;
  localparam logic [MUL_W-1:0]  DEG_UNITS  = MUL_W'(11796480);
  localparam logic [24:0]       LS_FULL    = 25'd23592960;

  // Bitwise long division, quotient only.
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // round(num / den * 2^fb), half up
  function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                           input int fb);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    for (int i = 0; i < fb + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] v;
    logic [63:0] term;
    v = '0;
    if (i == 0) begin
      v = frac_div(PI_DEC, 64'd4 * DEC_ONE, 62);
    end else begin
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = udiv(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        if ((k % 2) == 1) v = v - term;
        else              v = v + term;
      end
    end
    return (v + (64'd1 << (61 - FRAC_W))) >> (62 - FRAC_W);
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    for (int i = 0; i < ATAN_DEPTH; i++) t[i] = WORD_W'(atan_entry(i));
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  localparam logic [63:0] PI_U64  = frac_div(PI_DEC, DEC_ONE, FRAC_W);
  localparam word_t PI_Q      = WORD_W'(PI_U64);
  localparam word_t TWO_PI    = WORD_W'(PI_U64 << 1);
  localparam word_t HALF_PI   = WORD_W'(PI_U64 >> 1);
  localparam word_t GAIN_Q    = WORD_W'(frac_div(GAIN_DEC, DEC_ONE, FRAC_W));
  localparam word_t ECC_Q     = WORD_W'(frac_div(64'd934, 64'd10000, FRAC_W));
  localparam word_t SQRT_TERM = WORD_W'(frac_div(64'd1098200602, 64'd1000000000, FRAC_W));
  localparam word_t THRESH    = WORD_W'(frac_div(64'd1, 64'd1000000, FRAC_W));
  localparam word_t INV_PI    = WORD_W'(frac_div(DEC_ONE, PI_DEC, FRAC_W));
  localparam word_t ONE_Q     = WORD_W'(64'd1 << FRAC_W);
  localparam word_t PERI_OFS  = WORD_W'(((PI_U64 << 1) *
                                         frac_div(64'd10901, 64'd36000, FRAC_W)
                                         + (64'd1 << (FRAC_W - 1))) >> FRAC_W);

endpackage

// ----- rtl/sol_to_solar_longitude.sv -----
// Sol number to Mars solar longitude, one word in, one word out.
// Sequencer around one shared divider, multiplier and CORDIC stage.
// Depends on sol2ls_pkg.
//
// Takes a sol number and returns Ls in 1/65536 degree (0 to 360 degrees, saturated).
// All arithmetic is Q6.28 fixed point. Each word runs N Newton steps, where N is
// 1 to MAX_NEWTON_STEPS; the time per word is set by the single CORDIC stage (one
// micro-rotation a cycle) and the radix-2 divider (one quotient bit a cycle) that
// every Newton step uses.
// The input stalls from acceptance until the result is loaded into the output register;
// a finished result waits there while the next sol is taken.
module sol_to_solar_longitude
  import sol2ls_pkg::*;
#(
  parameter int MAX_NEWTON_STEPS = 8,
  parameter int CORDIC_STEPS     = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] solar_day,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] ls_degrees
);

  localparam int CI_W = $clog2(CORDIC_STEPS);
  localparam int NC_W = $clog2(MAX_NEWTON_STEPS);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIV   = 5'd1;
  localparam logic [4:0] ST_MUL0  = 5'd2;
  localparam logic [4:0] ST_MUL1  = 5'd3;
  localparam logic [4:0] ST_SC0   = 5'd4;
  localparam logic [4:0] ST_SC1   = 5'd5;
  localparam logic [4:0] ST_SC2   = 5'd6;
  localparam logic [4:0] ST_CORD  = 5'd7;
  localparam logic [4:0] ST_SCEND = 5'd8;
  localparam logic [4:0] ST_KDONE = 5'd9;
  localparam logic [4:0] ST_MDIV  = 5'd10;
  localparam logic [4:0] ST_MSET  = 5'd11;
  localparam logic [4:0] ST_E0MUL = 5'd12;
  localparam logic [4:0] ST_E0SET = 5'd13;
  localparam logic [4:0] ST_NMS   = 5'd14;
  localparam logic [4:0] ST_NMC   = 5'd15;
  localparam logic [4:0] ST_NDIV  = 5'd16;
  localparam logic [4:0] ST_NUPD  = 5'd17;
  localparam logic [4:0] ST_FIN   = 5'd18;
  localparam logic [4:0] ST_NUMUL = 5'd19;
  localparam logic [4:0] ST_NUAT  = 5'd20;
  localparam logic [4:0] ST_LS1   = 5'd21;
  localparam logic [4:0] ST_LS2   = 5'd22;
  localparam logic [4:0] ST_LS3   = 5'd23;
  localparam logic [4:0] ST_DG1   = 5'd24;
  localparam logic [4:0] ST_DG2   = 5'd25;

  localparam logic CM_ROT = 1'b1;
  localparam logic CM_VEC = 1'b0;

  // sequencer
  logic [4:0] state;
  logic [4:0] ret;

  // shared divider
  logic [WORD_W-1:0] div_rem;
  logic [WORD_W-1:0] div_den;
  logic [WORD_W-1:0] div_q;
  logic [KDIV_W-1:0] div_dvd;
  logic [DCNT_W-1:0] div_cnt;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic               mul_neg;
  logic [2*MUL_W-1:0] mul_prod;
  word_t              mul_res;

  // shared CORDIC stage
  word_t       cx;
  word_t       cy;
  word_t       cz;
  logic [CI_W-1:0] ci;
  logic        cmode;
  logic        sneg;

  // working values
  word_t m;
  word_t e;
  word_t f;
  word_t s;
  word_t c;
  word_t ang;
  word_t ls;
  logic  neg_n;
  logic  below;
  logic [NC_W-1:0] ncnt;

  // combinational helpers
  logic [22:0]       sol100;
  logic              n_neg_w;
  logic [22:0]       n_abs;
  logic [WORD_W-1:0] div_try;
  logic              div_ge;
  logic [2*MUL_W-1:0] mul_rnd;
  logic [WORD_W-1:0] mul_mag;
  word_t             dx;
  word_t             dy;
  word_t             at;
  logic              up;
  logic [WORD_W-1:0] rabs;
  logic              below_w;
  logic [WORD_W-1:0] qround;
  word_t             e_next;
  word_t             den_raw;
  word_t             ls_fix;
  word_t             e_fin;
  logic [24:0]       deg_sat;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    sol100  = 23'(solar_day) * 23'd100;
    n_neg_w = sol100 < PERI_SOL100;
    n_abs   = n_neg_w ? (PERI_SOL100 - sol100) : (sol100 - PERI_SOL100);

    div_try = {div_rem[WORD_W-2:0], div_dvd[KDIV_W-1]};
    div_ge  = div_try >= div_den;

    mul_rnd = mul_prod + ((2*MUL_W)'(1) << (FRAC_W - 1));
    mul_mag = WORD_W'(mul_rnd >> FRAC_W);

    dx = cy >>> ci;
    dy = cx >>> ci;
    at = ATAN_TAB[ATAN_IDX_W'(ci)];
    up = (cmode == CM_ROT) ? (cz >= 0) : (cy < 0);

    // remainder of (|n| + half) against the orbit, folded to distance from perihelion
    rabs    = (div_rem >= HALF_SCALE) ? (div_rem - HALF_SCALE) : (HALF_SCALE - div_rem);
    below_w = neg_n ? (div_rem > HALF_SCALE) : (div_rem < HALF_SCALE);

    // step against the sign of the residual
    qround  = (div_q + WORD_W'(1)) >> 1;
    e_next  = (f > 0) ? (e - word_t'(qround)) : (e + word_t'(qround));
    den_raw = ONE_Q - mul_res;
    e_fin   = below ? -e : e;

    if (ls > TWO_PI)  ls_fix = ls - TWO_PI;
    else if (ls < 0)  ls_fix = '0;
    else              ls_fix = ls;

    deg_sat = (mul_res > word_t'(LS_FULL)) ? LS_FULL : mul_res[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the output word once taken, unless a new one loads this cycle
      if (out_valid && !out_stall && state != ST_DG2) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // integer divide for the orbit count, remainder is what matters
            neg_n   <= n_neg_w;
            div_rem <= '0;
            div_dvd <= n_abs + HALF_SCALE[22:0];
            div_den <= SOL_SCALE;
            div_q   <= '0;
            div_cnt <= DCNT_W'(KDIV_W - 1);
            ret     <= ST_KDONE;
            state   <= ST_DIV;
          end
        end

        ST_DIV: begin
          div_rem <= div_ge ? (div_try - div_den) : div_try;
          div_q   <= {div_q[WORD_W-2:0], div_ge};
          div_dvd <= div_dvd << 1;
          if (div_cnt == '0) state <= ret;
          else div_cnt <= div_cnt - 1'b1;
        end

        ST_MUL0: begin
          mul_prod <= mul_a * mul_b;
          state    <= ST_MUL1;
        end

        ST_MUL1: begin
          mul_res <= mul_neg ? -word_t'(mul_mag) : word_t'(mul_mag);
          state   <= ret;
        end

        ST_SC0: begin
          if (ang >= TWO_PI)       ang <= ang - TWO_PI;
          else if (ang <= -TWO_PI) ang <= ang + TWO_PI;
          state <= ST_SC1;
        end

        ST_SC1: begin
          if (ang > PI_Q)       ang <= ang - TWO_PI;
          else if (ang < -PI_Q) ang <= ang + TWO_PI;
          state <= ST_SC2;
        end

        ST_SC2: begin
          // fold into the right half plane, flip the result back at the end
          if (ang > HALF_PI) begin
            cz   <= ang - PI_Q;
            sneg <= 1'b1;
          end else if (ang < -HALF_PI) begin
            cz   <= ang + PI_Q;
            sneg <= 1'b1;
          end else begin
            cz   <= ang;
            sneg <= 1'b0;
          end
          cx    <= GAIN_Q;
          cy    <= '0;
          ci    <= '0;
          cmode <= CM_ROT;
          state <= ST_CORD;
        end

        ST_CORD: begin
          if (up) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + at;
          end
          if (ci == CI_W'(CORDIC_STEPS - 1)) state <= (cmode == CM_ROT) ? ST_SCEND : ret;
          else ci <= ci + 1'b1;
        end

        ST_SCEND: begin
          s     <= sneg ? -cy : cy;
          c     <= sneg ? -cx : cx;
          state <= ret;
        end

        ST_KDONE: begin
          below   <= below_w;
          div_rem <= rabs;
          div_dvd <= '0;
          div_den <= SOL_SCALE;
          div_q   <= '0;
          div_cnt <= DCNT_W'(FRAC_W);
          ret     <= ST_MDIV;
          state   <= ST_DIV;
        end

        ST_MDIV: begin
          mul_a   <= TWO_PI[MUL_W-1:0];
          mul_b   <= qround[MUL_W-1:0];
          mul_neg <= 1'b0;
          ret     <= ST_MSET;
          state   <= ST_MUL0;
        end

        ST_MSET: begin
          m     <= mul_res;
          ang   <= mul_res;
          ret   <= ST_E0MUL;
          state <= ST_SC0;
        end

        ST_E0MUL: begin
          mul_a   <= ECC_Q[MUL_W-1:0];
          mul_b   <= MUL_W'(s < 0 ? -s : s);
          mul_neg <= s < 0;
          ret     <= ST_E0SET;
          state   <= ST_MUL0;
        end

        ST_E0SET: begin
          e     <= m + mul_res;
          ang   <= m + mul_res;
          ncnt  <= '0;
          ret   <= ST_NMS;
          state <= ST_SC0;
        end

        ST_NMS: begin
          mul_a   <= ECC_Q[MUL_W-1:0];
          mul_b   <= MUL_W'(s < 0 ? -s : s);
          mul_neg <= s < 0;
          ret     <= ST_NMC;
          state   <= ST_MUL0;
        end

        ST_NMC: begin
          f       <= e - mul_res - m;
          mul_a   <= ECC_Q[MUL_W-1:0];
          mul_b   <= MUL_W'(c < 0 ? -c : c);
          mul_neg <= c < 0;
          ret     <= ST_NDIV;
          state   <= ST_MUL0;
        end

        ST_NDIV: begin
          // Newton step size |f| / (1 - e cos E)
          div_rem <= (f < 0) ? -f : f;
          div_den <= (den_raw <= 0) ? ONE_Q : den_raw;
          div_dvd <= '0;
          div_q   <= '0;
          div_cnt <= DCNT_W'(FRAC_W);
          ret     <= ST_NUPD;
          state   <= ST_DIV;
        end

        ST_NUPD: begin
          e <= e_next;
          if (qround < THRESH || ncnt == NC_W'(MAX_NEWTON_STEPS - 1)) begin
            state <= ST_FIN;
          end else begin
            ncnt  <= ncnt + 1'b1;
            ang   <= e_next;
            ret   <= ST_NMS;
            state <= ST_SC0;
          end
        end

        ST_FIN: begin
          ang   <= e_fin >>> 1;
          ret   <= ST_NUMUL;
          state <= ST_SC0;
        end

        ST_NUMUL: begin
          mul_a   <= SQRT_TERM[MUL_W-1:0];
          mul_b   <= MUL_W'(s < 0 ? -s : s);
          mul_neg <= s < 0;
          ret     <= ST_NUAT;
          state   <= ST_MUL0;
        end

        ST_NUAT: begin
          // quarter-turn a left half plane vector before vectoring
          if (c < 0) begin
            if (mul_res >= 0) begin
              cx <= mul_res;
              cy <= -c;
              cz <= HALF_PI;
            end else begin
              cx <= -mul_res;
              cy <= c;
              cz <= -HALF_PI;
            end
          end else begin
            cx <= c;
            cy <= mul_res;
            cz <= '0;
          end
          ci    <= '0;
          cmode <= CM_VEC;
          ret   <= ST_LS1;
          state <= ST_CORD;
        end

        ST_LS1: begin
          ls    <= (cz <<< 1) - PERI_OFS;
          state <= ST_LS2;
        end

        ST_LS2: begin
          if (ls < 0) ls <= ls + TWO_PI;
          state <= ST_LS3;
        end

        ST_LS3: begin
          mul_a   <= ls_fix[MUL_W-1:0];
          mul_b   <= INV_PI[MUL_W-1:0];
          mul_neg <= 1'b0;
          ret     <= ST_DG1;
          state   <= ST_MUL0;
        end

        ST_DG1: begin
          mul_a   <= mul_res[MUL_W-1:0];
          mul_b   <= DEG_UNITS;
          mul_neg <= 1'b0;
          ret     <= ST_DG2;
          state   <= ST_MUL0;
        end

        ST_DG2: begin
          // hold here while the previous word still waits
          if (!out_valid || !out_stall) begin
            ls_degrees <= deg_sat;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ls_degrees <= LS_FULL)
    else $error("ls_degrees above full circle");

  a_cord_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> ci <= CI_W'(CORDIC_STEPS - 1))
    else $error("CORDIC index overrun");

  a_newton_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_NUPD |-> ncnt <= NC_W'(MAX_NEWTON_STEPS - 1))
    else $error("Newton count overrun");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DG2 && (!out_valid || !out_stall)) |=> out_valid && state == ST_IDLE)
    else $error("result not loaded");
`endif

endmodule
